// ----- hdl/rgb_to_yuyv_window_packer_assert.svh -----
// Assertion macros used by the checker of the window packer.
// Both sample on the rising edge of clk and are disabled while rst_n is low.
`ifndef RGB_TO_YUYV_WINDOW_PACKER_ASSERT_SVH
`define RGB_TO_YUYV_WINDOW_PACKER_ASSERT_SVH

// Same-cycle implication
`define RTYW_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgb_to_yuyv_window_packer: assertion failed");

// Next-cycle implication
`define RTYW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgb_to_yuyv_window_packer: assertion failed");

`endif

// ----- hdl/rgb2yuyv_pkg.sv -----
package rgb2yuyv_pkg;

    // APB byte address width: six 32-bit registers
    localparam int ADDR_W = 5;
    // Holds any fitted size, up to 8192
    localparam int SIZE_W = 14;
    // Holds any row or column position, up to 8191
    localparam int POS_W  = 13;
    // Pair command queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Register indexes on the APB port, at byte address 4 * index
    typedef enum logic [2:0]
    {
        REG_SRC_WIDTH  = 3'd0,
        REG_SRC_HEIGHT = 3'd1,
        REG_DST_WIDTH  = 3'd2,
        REG_DST_HEIGHT = 3'd3,
        REG_ORIGIN_X   = 3'd4,
        REG_ORIGIN_Y   = 3'd5
    } reg_idx_t;
    localparam int REG_COUNT = 6;

    typedef struct packed {
        logic       frame_start;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pix_t;

    typedef struct packed {
        logic [24:0] dst_offset;
        logic [7:0]  luma_first;
        logic [7:0]  chroma_blue;
        logic [7:0]  luma_second;
        logic [7:0]  chroma_red;
    } word_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    // Copy region derived from the configuration registers
    typedef struct packed {
        logic [SIZE_W-1:0] sw;
        logic [SIZE_W-1:0] sh;
        logic [SIZE_W-1:0] dw;
        logic [SIZE_W-1:0] dh;
        logic [SIZE_W-1:0] sx;
        logic [SIZE_W-1:0] sy;
        logic [SIZE_W-1:0] cw;
        logic [SIZE_W-1:0] ch;
    } geom_t;

    // One pair to pack, passed from the front to the back
    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] pair_col;
        rgb_t             first;
        rgb_t             second;
        logic             has_second;
    } cmd_t;

endpackage

// ----- hdl/rgb_to_yuyv_window_packer.sv -----
// RGB888 to YUYV 4:2:2 window packer. Source pixels arrive on the src channel in raster
// order, one per clock at full rate while src_stall is low; frame_start on a pixel restarts
// the row and column count. Pixels inside the copy region (source clipped to the destination
// at the clamped origin) are paired, and each pair yields one YUYV word with its destination
// byte offset on the dst channel; an odd copy width pairs the last pixel of a row with black.
// A word is registered in stages s1 and s2 and then in the output register after its pair
// leaves the four-entry command queue, so a stalled sink is absorbed for a few pairs before
// src_stall rises. A configuration write stalls the src channel for one cycle while the copy
// region is recomputed, and so does the first cycle after reset.
module rgb_to_yuyv_window_packer #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            src_valid,
    output logic                            src_stall,
    input  rgb2yuyv_pkg::pix_t              src_pixel,
    output logic                            dst_valid,
    input  logic                            dst_stall,
    output rgb2yuyv_pkg::word_t             dst_word,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rgb2yuyv_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    rgb2yuyv_pkg::geom_t geom;
    rgb2yuyv_pkg::cmd_t  push_cmd;
    rgb2yuyv_pkg::cmd_t  head;
    logic cfg_busy;
    logic accept;
    logic push;
    logic pop;
    logic head_valid;
    logic queue_full;

    assign src_stall = cfg_busy | queue_full;
    assign accept    = src_valid & ~src_stall;

    rgb2yuyv_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .geom    (geom),
        .busy    (cfg_busy)
    );

    rgb2yuyv_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .pixel  (src_pixel),
        .geom   (geom),
        .push   (push),
        .cmd    (push_cmd)
    );

    rgb2yuyv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .pop       (pop),
        .head      (head),
        .not_empty (head_valid),
        .full      (queue_full)
    );

    rgb2yuyv_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .geom       (geom),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .out_valid  (dst_valid),
        .out_stall  (dst_stall),
        .out_word   (dst_word)
    );

endmodule

// ----- hdl/rgb2yuyv_cfg.sv -----
module rgb2yuyv_cfg #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rgb2yuyv_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output rgb2yuyv_pkg::geom_t              geom,
    output logic                             busy
);

    localparam int SizeW = rgb2yuyv_pkg::SIZE_W;

    logic [12:0] src_width_reg;
    logic [12:0] src_height_reg;
    logic [12:0] dst_width_reg;
    logic [12:0] dst_height_reg;
    logic [11:0] origin_x_reg;
    logic [11:0] origin_y_reg;
    logic        hold_reg;
    rgb2yuyv_pkg::geom_t geom_reg;
    rgb2yuyv_pkg::geom_t geom_next;

    logic       wr_en;
    logic [2:0] reg_idx;

    logic [SizeW-1:0] ox;
    logic [SizeW-1:0] oy;
    logic [SizeW-1:0] dw_room;
    logic [SizeW-1:0] dh_room;

    function automatic logic [SizeW-1:0] fit_size(input logic [12:0] v,
                                                  input logic [SizeW-1:0] maxv);
        logic [SizeW-1:0] ext;
        begin
            ext = SizeW'(v);
            if (ext == '0)
                return SizeW'(1);
            else if (ext > maxv)
                return maxv;
            return ext;
        end
    endfunction

    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= 13'd640;
            src_height_reg <= 13'd360;
            dst_width_reg  <= 13'd640;
            dst_height_reg <= 13'd360;
            origin_x_reg   <= 12'd0;
            origin_y_reg   <= 12'd0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                rgb2yuyv_pkg::REG_SRC_WIDTH:  src_width_reg  <= pwdata[12:0];
                rgb2yuyv_pkg::REG_SRC_HEIGHT: src_height_reg <= pwdata[12:0];
                rgb2yuyv_pkg::REG_DST_WIDTH:  dst_width_reg  <= pwdata[12:0];
                rgb2yuyv_pkg::REG_DST_HEIGHT: dst_height_reg <= pwdata[12:0];
                rgb2yuyv_pkg::REG_ORIGIN_X:   origin_x_reg   <= pwdata[11:0];
                rgb2yuyv_pkg::REG_ORIGIN_Y:   origin_y_reg   <= pwdata[11:0];
                default:                      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            rgb2yuyv_pkg::REG_SRC_WIDTH:  prdata = 32'(src_width_reg);
            rgb2yuyv_pkg::REG_SRC_HEIGHT: prdata = 32'(src_height_reg);
            rgb2yuyv_pkg::REG_DST_WIDTH:  prdata = 32'(dst_width_reg);
            rgb2yuyv_pkg::REG_DST_HEIGHT: prdata = 32'(dst_height_reg);
            rgb2yuyv_pkg::REG_ORIGIN_X:   prdata = 32'(origin_x_reg);
            rgb2yuyv_pkg::REG_ORIGIN_Y:   prdata = 32'(origin_y_reg);
            default:                      prdata = '0;
        endcase
    end

    // Clamp origin into the frame, then clip the source to what is left
    always_comb
    begin
        geom_next.sw = fit_size(src_width_reg,  SizeW'(MAX_WIDTH));
        geom_next.sh = fit_size(src_height_reg, SizeW'(MAX_HEIGHT));
        geom_next.dw = fit_size(dst_width_reg,  SizeW'(MAX_WIDTH));
        geom_next.dh = fit_size(dst_height_reg, SizeW'(MAX_HEIGHT));
        ox = SizeW'(origin_x_reg);
        oy = SizeW'(origin_y_reg);
        geom_next.sx = (ox < geom_next.dw - SizeW'(1)) ? ox : geom_next.dw - SizeW'(1);
        geom_next.sy = (oy < geom_next.dh - SizeW'(1)) ? oy : geom_next.dh - SizeW'(1);
        dw_room = geom_next.dw - geom_next.sx;
        dh_room = geom_next.dh - geom_next.sy;
        geom_next.cw = (dw_room < geom_next.sw) ? dw_room : geom_next.sw;
        geom_next.ch = (dh_room < geom_next.sh) ? dh_room : geom_next.sh;
    end

    always_ff @(posedge clk)
    begin
        geom_reg <= geom_next;
    end

    // Hold off pixels for the cycle in which the region is being recomputed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_reg <= 1'b1;
        else
            hold_reg <= wr_en;
    end

    assign geom = geom_reg;
    assign busy = hold_reg;

endmodule

// ----- hdl/rgb2yuyv_front.sv -----
module rgb2yuyv_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  rgb2yuyv_pkg::pix_t    pixel,
    input  rgb2yuyv_pkg::geom_t   geom,
    output logic                  push,
    output rgb2yuyv_pkg::cmd_t    cmd
);

    localparam int SizeW = rgb2yuyv_pkg::SIZE_W;
    localparam int PosW  = rgb2yuyv_pkg::POS_W;
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);

    logic [WW-1:0]      col_reg;
    logic [WW-1:0]      col_next;
    logic [HW-1:0]      row_reg;
    logic [HW-1:0]      row_next;
    rgb2yuyv_pkg::rgb_t held_reg;
    rgb2yuyv_pkg::rgb_t cur;

    logic [WW-1:0] col0;
    logic [WW-1:0] col1;
    logic [WW-1:0] colp;
    logic [HW-1:0] row0;
    logic [HW-1:0] row1;
    logic [HW-1:0] row2;
    logic [HW-1:0] row3;
    logic          in_region;
    logic          odd;
    logic          last;
    logic          emit;

    assign cur = '{r: pixel.red, g: pixel.green, b: pixel.blue};

    always_comb
    begin
        col0 = pixel.frame_start ? '0 : col_reg;
        row0 = pixel.frame_start ? '0 : row_reg;
        // A column beyond the width (after a resize) starts a new row
        if (SizeW'(col0) >= geom.sw)
        begin
            col1 = '0;
            row1 = row0 + HW'(1);
        end
        else
        begin
            col1 = col0;
            row1 = row0;
        end
        row2 = (SizeW'(row1) >= geom.sh) ? '0 : row1;

        in_region = (SizeW'(row2) < geom.ch) && (SizeW'(col1) < geom.cw);
        odd       = col1[0];
        last      = (SizeW'(col1) + SizeW'(1)) >= geom.cw;
        emit      = in_region && (odd || last);

        // Advance to the next source position
        colp = col1 + WW'(1);
        if (SizeW'(colp) >= geom.sw)
        begin
            col_next = '0;
            row3     = row2 + HW'(1);
            row_next = (SizeW'(row3) >= geom.sh) ? '0 : row3;
        end
        else
        begin
            col_next = colp;
            row3     = row2;
            row_next = row2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            held_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (in_region && !odd)
                held_reg <= cur;
        end
    end

    assign push           = accept & emit;
    assign cmd.row        = PosW'(row2);
    assign cmd.pair_col   = PosW'({col1[WW-1:1], 1'b0});
    assign cmd.first      = odd ? held_reg : cur;
    assign cmd.second     = cur;
    assign cmd.has_second = odd;

endmodule

// ----- hdl/rgb2yuyv_queue.sv -----
module rgb2yuyv_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  rgb2yuyv_pkg::cmd_t push_data,
    input  logic               pop,
    output rgb2yuyv_pkg::cmd_t head,
    output logic               not_empty,
    output logic               full
);

    localparam int Depth = rgb2yuyv_pkg::QUEUE_DEPTH;
    localparam int PtrW  = rgb2yuyv_pkg::QPTR_W;
    localparam int CntW  = rgb2yuyv_pkg::QCNT_W;

    rgb2yuyv_pkg::cmd_t entry_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic            do_push;
    logic            do_pop;

    assign full      = (count_reg == CntW'(Depth));
    assign not_empty = (count_reg != '0);
    assign do_push   = push & ~full;
    assign do_pop    = pop & not_empty;
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CntW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CntW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + PtrW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + PtrW'(1);
            count_reg <= count_next;
        end
    end

endmodule

// ----- hdl/rgb2yuyv_back.sv -----
module rgb2yuyv_back (
    input  logic                clk,
    input  logic                rst_n,
    input  rgb2yuyv_pkg::geom_t geom,
    input  rgb2yuyv_pkg::cmd_t  head,
    input  logic                head_valid,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output rgb2yuyv_pkg::word_t out_word
);

    localparam int SizeW = rgb2yuyv_pkg::SIZE_W;

    localparam logic [15:0] LUMA_R     = 16'd77;
    localparam logic [15:0] LUMA_G     = 16'd150;
    localparam logic [15:0] LUMA_B     = 16'd29;
    localparam logic [15:0] U_R        = 16'd43;
    localparam logic [15:0] U_G        = 16'd85;
    localparam logic [15:0] V_G        = 16'd107;
    localparam logic [15:0] V_B        = 16'd21;
    // 128 * 256: turns the signed chroma sum into floor(sum / 256) + 128
    localparam logic [15:0] CHROMA_BIAS = 16'h8000;

    logic adv;

    logic             s1_valid_reg;
    logic [SizeW-1:0] s1_line_reg;
    logic [SizeW-1:0] s1_colb_reg;
    logic [15:0]      s1_y1_reg;
    logic [15:0]      s1_u_reg;
    logic [15:0]      s1_v_reg;
    logic [15:0]      s1_y2_reg;

    logic             s2_valid_reg;
    logic [24:0]      s2_prod_reg;
    logic [SizeW-1:0] s2_colb_reg;
    logic [7:0]       s2_y1_reg;
    logic [7:0]       s2_u_reg;
    logic [7:0]       s2_v_reg;
    logic [7:0]       s2_y2_reg;

    logic                out_valid_reg;
    rgb2yuyv_pkg::word_t out_reg;

    logic [15:0]      y1_next;
    logic [15:0]      u_next;
    logic [15:0]      v_next;
    logic [15:0]      y2_next;
    logic [2*SizeW-1:0] prod_full;
    logic [24:0]      pix_index;

    // The whole pipeline moves unless a finished word is held by the sink
    assign adv = ~out_valid_reg | ~out_stall;
    assign pop = adv & head_valid;

    always_comb
    begin
        y1_next = 16'(head.first.r) * LUMA_R + 16'(head.first.g) * LUMA_G
                + 16'(head.first.b) * LUMA_B;
        u_next  = CHROMA_BIAS + (16'(head.first.b) << 7)
                - 16'(head.first.r) * U_R - 16'(head.first.g) * U_G;
        v_next  = CHROMA_BIAS + (16'(head.first.r) << 7)
                - 16'(head.first.g) * V_G - 16'(head.first.b) * V_B;
        y2_next = head.has_second
                ? 16'(head.second.r) * LUMA_R + 16'(head.second.g) * LUMA_G
                  + 16'(head.second.b) * LUMA_B
                : '0;
        prod_full = (2*SizeW)'(s1_line_reg) * (2*SizeW)'(geom.dw);
        pix_index = s2_prod_reg + 25'(s2_colb_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= pop;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_line_reg <= geom.sy + SizeW'(head.row);
            s1_colb_reg <= geom.sx + SizeW'(head.pair_col);
            s1_y1_reg   <= y1_next;
            s1_u_reg    <= u_next;
            s1_v_reg    <= v_next;
            s1_y2_reg   <= y2_next;

            s2_prod_reg <= prod_full[24:0];
            s2_colb_reg <= s1_colb_reg;
            s2_y1_reg   <= s1_y1_reg[15:8];
            s2_u_reg    <= s1_u_reg[15:8];
            s2_v_reg    <= s1_v_reg[15:8];
            s2_y2_reg   <= s1_y2_reg[15:8];

            out_reg.dst_offset  <= {pix_index[23:0], 1'b0};
            out_reg.luma_first  <= s2_y1_reg;
            out_reg.chroma_blue <= s2_u_reg;
            out_reg.luma_second <= s2_y2_reg;
            out_reg.chroma_red  <= s2_v_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

endmodule

// ----- hdl/rgb2yuyv_checker.sv -----
`include "rgb_to_yuyv_window_packer_assert.svh"

module rgb2yuyv_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                src_valid,
    input logic                src_stall,
    input rgb2yuyv_pkg::pix_t  src_pixel,
    input logic                dst_valid,
    input logic                dst_stall,
    input rgb2yuyv_pkg::word_t dst_word,
    input logic                psel,
    input logic                penable,
    input logic                pwrite,
    input logic                pready
);

    // A held word stays put until taken
    `RTYW_ASSERT_NEXT(a_dst_hold, dst_valid && dst_stall, dst_valid && $stable(dst_word))

    // A stalled pixel stays put until taken
    `RTYW_ASSERT_NEXT(a_src_hold, src_valid && src_stall, src_valid && $stable(src_pixel))

    // YUYV words sit on two-byte pixel boundaries
    `RTYW_ASSERT_IMP(a_offset_even, dst_valid, dst_word.dst_offset[0] == 1'b0)

    // No pixel is taken while the copy region is being recomputed
    `RTYW_ASSERT_NEXT(a_cfg_stall, psel && penable && pwrite && pready, src_stall)

endmodule

bind rgb_to_yuyv_window_packer rgb2yuyv_checker u_checker (.*);

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int MAX_W       = 4096;
    localparam int MAX_H       = 4096;
    localparam int IDLE_MAX    = 11;
    localparam int TAIL_CYCLES = 16;

    logic                              clk;
    logic                              rst_n;
    logic                              src_valid;
    logic                              src_stall;
    rgb2yuyv_pkg::pix_t                src_pixel;
    logic                              dst_valid;
    logic                              dst_stall;
    rgb2yuyv_pkg::word_t               dst_word;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [rgb2yuyv_pkg::ADDR_W-1:0]   paddr;
    logic [31:0]                       pwdata;
    logic [31:0]                       prdata;
    logic                              pready;

    // Shadow of the block's registers and pixel position
    int unsigned         reg_val [rgb2yuyv_pkg::REG_COUNT];
    int unsigned         row_pos;
    int unsigned         col_pos;
    rgb2yuyv_pkg::rgb_t  held;
    rgb2yuyv_pkg::word_t words_due [$];
    rgb2yuyv_pkg::word_t word_want;

    int                  err_count;
    int                  stall_left;
    bit                  src_idle;
    bit                  dst_idle;

    rgb_to_yuyv_window_packer #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_pixel (src_pixel),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_word  (dst_word),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    function automatic int unsigned fit_dim(input int unsigned v, input int unsigned lim);
        if (v == 0)
            return 1;
        return (v > lim) ? lim : v;
    endfunction

    function automatic logic [7:0] luma8(input rgb2yuyv_pkg::rgb_t c);
        int s;
        s = 77 * int'(c.r) + 150 * int'(c.g) + 29 * int'(c.b);
        return s[15:8];
    endfunction

    // Offset by 128*256 before the shift so that it floors, then clamp
    function automatic logic [7:0] chroma8(input int sum);
        int t;
        t = (sum + 32768) >>> 8;
        if (t < 0)
            t = 0;
        if (t > 255)
            t = 255;
        return t[7:0];
    endfunction

    function automatic void pack_pixel(input rgb2yuyv_pkg::pix_t p);
        int unsigned         sw, sh, dw, dh, sx, sy, cw, ch, pc, off, ox, oy;
        int                  fr, fg, fb;
        bit                  emit;
        rgb2yuyv_pkg::rgb_t  cur;
        rgb2yuyv_pkg::word_t w;
        sw = fit_dim(reg_val[rgb2yuyv_pkg::REG_SRC_WIDTH], MAX_W);
        sh = fit_dim(reg_val[rgb2yuyv_pkg::REG_SRC_HEIGHT], MAX_H);
        dw = fit_dim(reg_val[rgb2yuyv_pkg::REG_DST_WIDTH], MAX_W);
        dh = fit_dim(reg_val[rgb2yuyv_pkg::REG_DST_HEIGHT], MAX_H);
        ox = reg_val[rgb2yuyv_pkg::REG_ORIGIN_X];
        oy = reg_val[rgb2yuyv_pkg::REG_ORIGIN_Y];
        sx = (ox < dw - 1) ? ox : dw - 1;
        sy = (oy < dh - 1) ? oy : dh - 1;
        cw = (dw - sx < sw) ? dw - sx : sw;
        ch = (dh - sy < sh) ? dh - sy : sh;
        cur = {p.red, p.green, p.blue};
        w = '0;
        emit = 1'b0;

        if (p.frame_start)
        begin
            row_pos = 0;
            col_pos = 0;
        end
        // Wrap a position left beyond a size that has just shrunk
        if (col_pos >= sw)
        begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= sh)
            row_pos = 0;

        if (row_pos < ch && col_pos < cw)
        begin
            if (col_pos[0] == 1'b0)
            begin
                held = cur;
                emit = (col_pos + 1 >= cw);
            end
            else
            begin
                w.luma_second = luma8(cur);
                emit = 1'b1;
            end
            if (emit)
            begin
                pc = col_pos & ~32'd1;
                off = ((sy + row_pos) * dw + sx + pc) * 2;
                fr = int'(held.r);
                fg = int'(held.g);
                fb = int'(held.b);
                w.dst_offset  = off[24:0];
                w.luma_first  = luma8(held);
                w.chroma_blue = chroma8(-43 * fr - 85 * fg + 128 * fb);
                w.chroma_red  = chroma8(128 * fr - 107 * fg - 21 * fb);
                words_due.push_back(w);
            end
        end

        col_pos++;
        if (col_pos >= sw)
        begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= sh)
                row_pos = 0;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        err_count++;
    endtask

    function automatic rgb2yuyv_pkg::pix_t make_pixel(input bit fs, input logic [7:0] r, g, b);
        rgb2yuyv_pkg::pix_t p;
        p.frame_start = fs;
        p.red         = r;
        p.green       = g;
        p.blue        = b;
        return p;
    endfunction

    function automatic rgb2yuyv_pkg::pix_t rand_pixel(input bit fs);
        return make_pixel(fs, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)));
    endfunction

    // Entered and left at a falling edge
    task automatic send_pixel(input rgb2yuyv_pkg::pix_t p);
        int gap;
        gap = src_idle ? $urandom_range(0, IDLE_MAX) : 0;
        if (gap > 0)
        begin
            src_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        src_valid <= 1'b1;
        src_pixel <= p;
        do
            @(posedge clk);
        while (!(src_valid && !src_stall));
        pack_pixel(p);
        @(negedge clk);
    endtask

    task automatic wait_pipeline_empty();
        src_valid <= 1'b0;
        while (words_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    // Write all six registers back to back; call only while the block is idle
    task automatic program_window(input logic [31:0] sw, sh, dw, dh, ox, oy);
        logic [31:0]            vals [rgb2yuyv_pkg::REG_COUNT];
        logic [31:0]            v;
        rgb2yuyv_pkg::reg_idx_t idx;
        vals[rgb2yuyv_pkg::REG_SRC_WIDTH]  = sw;
        vals[rgb2yuyv_pkg::REG_SRC_HEIGHT] = sh;
        vals[rgb2yuyv_pkg::REG_DST_WIDTH]  = dw;
        vals[rgb2yuyv_pkg::REG_DST_HEIGHT] = dh;
        vals[rgb2yuyv_pkg::REG_ORIGIN_X]   = ox;
        vals[rgb2yuyv_pkg::REG_ORIGIN_Y]   = oy;
        for (int i = 0; i < rgb2yuyv_pkg::REG_COUNT; i++)
        begin
            idx = rgb2yuyv_pkg::reg_idx_t'(i);
            v = vals[i];
            // Junk above the register width must be dropped
            if ($urandom_range(0, 3) == 0)
            begin
                if (idx == rgb2yuyv_pkg::REG_ORIGIN_X || idx == rgb2yuyv_pkg::REG_ORIGIN_Y)
                    v[31:12] = 20'($urandom);
                else
                    v[31:13] = 19'($urandom);
            end
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= rgb2yuyv_pkg::ADDR_W'(4 * i);
            pwdata  <= v;
            @(negedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
            if (idx == rgb2yuyv_pkg::REG_ORIGIN_X || idx == rgb2yuyv_pkg::REG_ORIGIN_Y)
                reg_val[idx] = 32'(v[11:0]);
            else
                reg_val[idx] = 32'(v[12:0]);
            @(negedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mostly whole frames with random content, some cut short or restarted
    task automatic send_stream(input int budget, input bit first_clean);
        int unsigned frame_len;
        int          sent, len;
        bit          clean, fs;
        sent = 0;
        clean = first_clean;
        while (sent < budget)
        begin
            frame_len = fit_dim(reg_val[rgb2yuyv_pkg::REG_SRC_WIDTH], MAX_W)
                        * fit_dim(reg_val[rgb2yuyv_pkg::REG_SRC_HEIGHT], MAX_H);
            len = (frame_len < budget - sent) ? frame_len : budget - sent;
            if ($urandom_range(0, 7) == 0)
                len = $urandom_range(1, len);
            src_idle = ($urandom_range(0, 3) != 0);
            dst_idle = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < len; k++)
            begin
                fs = (k == 0 && clean) || ($urandom_range(0, 59) == 0);
                send_pixel(rand_pixel(fs));
            end
            sent += len;
            clean = ($urandom_range(0, 9) != 0);
        end
    endtask

    function automatic logic [31:0] extreme_size();
        unique case ($urandom_range(0, 4))
            0: return 0;
            1: return 1;
            2: return 4095;
            3: return 4096;
            default: return 8191;
        endcase
    endfunction

    task automatic test_reset_defaults();
        src_idle = 1'b0;
        dst_idle = 1'b0;
        send_pixel(make_pixel(1'b1, 8'd0, 8'd0, 8'd0));
        send_pixel(make_pixel(1'b0, 8'd255, 8'd255, 8'd255));
        send_pixel(make_pixel(1'b0, 8'd255, 8'd0, 8'd0));
        send_pixel(make_pixel(1'b0, 8'd0, 8'd255, 8'd0));
        send_pixel(make_pixel(1'b0, 8'd0, 8'd0, 8'd255));
        send_pixel(make_pixel(1'b0, 8'd128, 8'd64, 8'd200));
    endtask

    // Odd copy width, clipped columns, row and frame wrap
    task automatic test_odd_window();
        wait_pipeline_empty();
        program_window(5, 2, 4, 3, 1, 1);
        src_idle = 1'b1;
        dst_idle = 1'b1;
        for (int k = 0; k < 10; k++)
            send_pixel(rand_pixel(k == 0));
    endtask

    // Zero and oversized registers, clamped origins, largest offset
    task automatic test_size_limits();
        wait_pipeline_empty();
        program_window(0, 8191, 8191, 0, 4095, 4095);
        send_pixel(make_pixel(1'b1, 8'd255, 8'd0, 8'd255));
        send_pixel(rand_pixel(1'b0));
        send_pixel(rand_pixel(1'b0));
        send_pixel(make_pixel(1'b1, 8'd0, 8'd255, 8'd0));
        send_pixel(rand_pixel(1'b0));
        wait_pipeline_empty();
        program_window(8191, 8191, 4096, 4096, 4095, 4095);
        send_pixel(rand_pixel(1'b1));
        send_pixel(rand_pixel(1'b0));
    endtask

    task automatic test_random_windows(input int phases, input int per_phase);
        logic [31:0] sw, sh, dw, dh, ox, oy;
        for (int ph = 0; ph < phases; ph++)
        begin
            wait_pipeline_empty();
            if ($urandom_range(0, 5) == 0)
            begin
                sw = extreme_size();
                sh = extreme_size();
                dw = extreme_size();
                dh = extreme_size();
                ox = $urandom_range(0, 1) ? 4095 : 0;
                oy = $urandom_range(0, 1) ? 4095 : 0;
            end
            else
            begin
                sw = $urandom_range(1, 12);
                sh = $urandom_range(1, 5);
                dw = $urandom_range(1, 16);
                dh = $urandom_range(1, 8);
                ox = $urandom_range(0, dw + 1);
                oy = $urandom_range(0, dh + 1);
            end
            program_window(sw, sh, dw, dh, ox, oy);
            // Now and then carry on mid-frame under the new window
            send_stream(per_phase, $urandom_range(0, 2) != 0);
        end
    endtask

    // Burst at full rate into a stalling sink, hold off until drained, resume
    task automatic test_drain_pause();
        wait_pipeline_empty();
        program_window(9, 4, 12, 6, 2, 1);
        src_idle = 1'b0;
        dst_idle = 1'b1;
        for (int k = 0; k < 30; k++)
            send_pixel(rand_pixel(k == 0));
        wait_pipeline_empty();
        for (int k = 0; k < 30; k++)
            send_pixel(rand_pixel(1'b0));
    endtask

    // Sink side: hold stall for the drawn number of cycles after each transaction
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            dst_stall <= 1'b1;
            stall_left = stall_left - 1;
        end
        else
            dst_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && dst_valid && !dst_stall)
        begin
            if (words_due.size() == 0)
                report_mismatch($sformatf("unexpected word at offset %0d",
                                          dst_word.dst_offset));
            else
            begin
                word_want = words_due.pop_front();
                if (dst_word.dst_offset !== word_want.dst_offset)
                    report_mismatch($sformatf("dst_offset %0d, want %0d",
                                              dst_word.dst_offset, word_want.dst_offset));
                if (dst_word.luma_first !== word_want.luma_first)
                    report_mismatch($sformatf("luma_first %0d, want %0d",
                                              dst_word.luma_first, word_want.luma_first));
                if (dst_word.chroma_blue !== word_want.chroma_blue)
                    report_mismatch($sformatf("chroma_blue %0d, want %0d",
                                              dst_word.chroma_blue, word_want.chroma_blue));
                if (dst_word.luma_second !== word_want.luma_second)
                    report_mismatch($sformatf("luma_second %0d, want %0d",
                                              dst_word.luma_second, word_want.luma_second));
                if (dst_word.chroma_red !== word_want.chroma_red)
                    report_mismatch($sformatf("chroma_red %0d, want %0d",
                                              dst_word.chroma_red, word_want.chroma_red));
            end
            stall_left = dst_idle ? $urandom_range(0, IDLE_MAX) : 0;
        end
    end

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int wait_cnt;
        rst_n      = 1'b0;
        src_valid  = 1'b0;
        src_pixel  = '0;
        dst_stall  = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        stall_left = 0;
        err_count  = 0;
        src_idle   = 1'b0;
        dst_idle   = 1'b0;
        reg_val[rgb2yuyv_pkg::REG_SRC_WIDTH]  = 640;
        reg_val[rgb2yuyv_pkg::REG_SRC_HEIGHT] = 360;
        reg_val[rgb2yuyv_pkg::REG_DST_WIDTH]  = 640;
        reg_val[rgb2yuyv_pkg::REG_DST_HEIGHT] = 360;
        reg_val[rgb2yuyv_pkg::REG_ORIGIN_X]   = 0;
        reg_val[rgb2yuyv_pkg::REG_ORIGIN_Y]   = 0;
        row_pos = 0;
        col_pos = 0;
        held    = '0;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_odd_window();
        test_size_limits();
        test_drain_pause();
        test_random_windows(14, 105);

        src_valid <= 1'b0;
        wait_cnt = 0;
        while (words_due.size() != 0 && wait_cnt < 5000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        if (words_due.size() != 0)
            report_mismatch($sformatf("%0d words never arrived", words_due.size()));
        repeat (TAIL_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
